### sv/abr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abr_pkg;

  localparam int TimeW  = 32;
  localparam int CountW = 16;
  localparam int IdxW   = 10;
  localparam int BitsW  = 4;

  localparam int BufferBytesDef    = 1024;
  localparam int SyncEdgesDef      = 4;
  localparam int SilencePeriodsDef = 32;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_SYNC  = 3'd1,
    PH_TRACK = 3'd2,
    PH_RECV  = 3'd3,
    PH_DONE  = 3'd4
  } phase_e;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic div_load;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } stat_t;

endpackage

`default_nettype wire

### sv/abr_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Shift-subtract divider: one quotient bit per cycle.
module abr_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [abr_pkg::TimeW-1:0]   dividend_i,
  input  wire logic [abr_pkg::CountW-1:0]  divisor_i,
  output logic                             done_o,
  output logic [abr_pkg::TimeW-1:0]        quot_o
);

  localparam int StepW = $clog2(abr_pkg::TimeW + 1);

  logic [StepW-1:0]              cnt_q;
  logic                          done_q;
  logic [abr_pkg::TimeW-1:0]     quo_q;
  logic [abr_pkg::CountW-1:0]    rem_q;
  logic [abr_pkg::CountW-1:0]    dvs_q;
  logic [abr_pkg::CountW:0]      rem_shift;
  logic                          fits;

  assign rem_shift = {rem_q, quo_q[abr_pkg::TimeW-1]};
  assign fits      = rem_shift >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == StepW'(1));
      if (start_i) begin
        cnt_q <= StepW'(abr_pkg::TimeW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[abr_pkg::TimeW-2:0], fits};
      if (fits) begin
        rem_q <= abr_pkg::CountW'(rem_shift - {1'b0, dvs_q});
      end else begin
        rem_q <= rem_shift[abr_pkg::CountW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

### sv/abr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module abr_dp #(
  parameter int BUFFER_BYTES    = abr_pkg::BufferBytesDef,
  parameter int SYNC_EDGES      = abr_pkg::SyncEdgesDef,
  parameter int SILENCE_PERIODS = abr_pkg::SilencePeriodsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire abr_pkg::cmd_t               cmd_i,
  output abr_pkg::stat_t                   stat_o,
  input  wire logic                        op_i,
  input  wire logic [abr_pkg::TimeW-1:0]   sample_time_i,
  input  wire logic                        pin_level_i,
  output logic [2:0]                       phase_o,
  output logic [abr_pkg::TimeW-1:0]        bit_period_o,
  output logic                             byte_valid_o,
  output logic [7:0]                       byte_value_o,
  output logic [abr_pkg::IdxW-1:0]         byte_index_o,
  output logic [abr_pkg::BitsW-1:0]        bits_in_byte_o,
  output logic                             done_res_o,
  output logic                             overflow_o
);

  localparam int TW    = abr_pkg::TimeW;
  localparam int CW    = abr_pkg::CountW;
  localparam int ByteW = $clog2(BUFFER_BYTES + 1);
  localparam int SilW  = $clog2(SILENCE_PERIODS + 1);
  localparam int SpanW = TW + SilW;
  localparam int LimW  = SpanW + 1;

  // Captured request
  logic          op_q;
  logic [TW-1:0] t_q;
  logic          pin_q;

  // Block state
  abr_pkg::phase_e  phase_q, phase_d;
  logic             level_q, level_d;
  logic [TW-1:0]    prev_q, prev_d;
  logic [TW-1:0]    next_q, next_d;
  logic [TW-1:0]    total_q, total_d;
  logic [CW-1:0]    count_q, count_d;
  logic [TW-1:0]    period_q;
  logic [7:0]       asm_q, asm_d;
  logic [2:0]       bitpos_q, bitpos_d;
  logic [ByteW-1:0] bytecnt_q, bytecnt_d;
  logic             ovf_q, ovf_d;

  // Silence limit, kept up to date in the background
  logic [SpanW-1:0] span_q;
  logic [LimW-1:0]  limit_q;

  // Per-request result
  logic                     res_bv_q, res_bv_d;
  logic [7:0]               res_val_q, res_val_d;
  logic [abr_pkg::IdxW-1:0] res_idx_q, res_idx_d;
  logic [abr_pkg::BitsW-1:0] res_bits_q, res_bits_d;
  logic                     res_done_q, res_done_d;

  logic                     need_div;
  logic                     div_done;
  logic [TW-1:0]            quot;

  // Output register
  abr_pkg::phase_e          out_phase_q;
  logic [TW-1:0]            out_period_q;
  logic                     out_bv_q;
  logic [7:0]               out_val_q;
  logic [abr_pkg::IdxW-1:0] out_idx_q;
  logic [abr_pkg::BitsW-1:0] out_bits_q;
  logic                     out_done_q;
  logic                     out_ovf_q;

  always_comb begin
    logic [TW-1:0]             half;
    logic [7:0]                asm_n;
    logic                      emit_en;
    logic [7:0]                emit_val;
    logic [abr_pkg::BitsW-1:0] emit_bits;

    phase_d    = phase_q;
    level_d    = level_q;
    prev_d     = prev_q;
    next_d     = next_q;
    total_d    = total_q;
    count_d    = count_q;
    asm_d      = asm_q;
    bitpos_d   = bitpos_q;
    bytecnt_d  = bytecnt_q;
    ovf_d      = ovf_q;
    need_div   = 1'b0;
    res_bv_d   = 1'b0;
    res_val_d  = '0;
    res_idx_d  = '0;
    res_bits_d = '0;
    res_done_d = 1'b0;
    emit_en    = 1'b0;
    emit_val   = '0;
    emit_bits  = '0;
    half       = period_q >> 1;
    asm_n      = asm_q | (8'(pin_q) << bitpos_q);

    if (op_q == abr_pkg::OP_RESTART) begin
      phase_d   = abr_pkg::PH_WAIT;
      level_d   = pin_q;
      prev_d    = '0;
      next_d    = '0;
      total_d   = '0;
      count_d   = '0;
      asm_d     = '0;
      bitpos_d  = '0;
      bytecnt_d = '0;
      ovf_d     = 1'b0;
    end else begin
      case (phase_q)
        abr_pkg::PH_WAIT: begin
          if (pin_q != level_q) begin
            prev_d  = t_q;
            level_d = pin_q;
            count_d = '0;
            phase_d = abr_pkg::PH_SYNC;
          end
        end
        abr_pkg::PH_SYNC: begin
          if (pin_q != level_q) begin
            level_d = pin_q;
            total_d = total_q + (t_q - prev_q);
            count_d = (count_q != abr_pkg::CountMax) ? count_q + CW'(1) : count_q;
            prev_d  = t_q;
            if (count_d >= CW'(SYNC_EDGES)) begin
              phase_d  = abr_pkg::PH_TRACK;
              need_div = 1'b1;
            end
          end
        end
        abr_pkg::PH_TRACK: begin
          if ({1'b0, t_q} > ({1'b0, next_q} + {1'b0, half})) begin
            phase_d   = abr_pkg::PH_RECV;
            next_d    = t_q + half;
            prev_d    = t_q;
            asm_d     = 8'(pin_q);
            bitpos_d  = 3'd1;
            bytecnt_d = '0;
            level_d   = pin_q;
          end else if (pin_q != level_q) begin
            level_d  = pin_q;
            total_d  = total_q + (t_q - prev_q);
            count_d  = (count_q != abr_pkg::CountMax) ? count_q + CW'(1) : count_q;
            prev_d   = t_q;
            need_div = 1'b1;
          end
        end
        abr_pkg::PH_RECV: begin
          if (t_q >= next_q) begin
            next_d = next_q + period_q;
            if (bitpos_q == 3'd7) begin
              emit_en   = 1'b1;
              emit_val  = asm_n;
              emit_bits = abr_pkg::BitsW'(8);
              asm_d     = '0;
              bitpos_d  = '0;
            end else begin
              asm_d    = asm_n;
              bitpos_d = bitpos_q + 3'd1;
            end
            if (level_q == pin_q) begin
              if (limit_q < LimW'(t_q)) begin
                phase_d    = abr_pkg::PH_DONE;
                res_done_d = 1'b1;
                // Flush a partial byte; a full byte was already cleared above
                if (bitpos_d != '0) begin
                  emit_en   = 1'b1;
                  emit_val  = asm_d;
                  emit_bits = abr_pkg::BitsW'(bitpos_d);
                  asm_d     = '0;
                  bitpos_d  = '0;
                end
              end
            end else begin
              level_d = pin_q;
              prev_d  = t_q;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (emit_en) begin
      if (bytecnt_q < ByteW'(BUFFER_BYTES)) begin
        res_bv_d   = 1'b1;
        res_val_d  = emit_val;
        res_idx_d  = abr_pkg::IdxW'(bytecnt_q);
        res_bits_d = emit_bits;
        bytecnt_d  = bytecnt_q + ByteW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= abr_pkg::PH_WAIT;
      level_q   <= 1'b0;
      prev_q    <= '0;
      next_q    <= '0;
      total_q   <= '0;
      count_q   <= '0;
      period_q  <= '0;
      asm_q     <= '0;
      bitpos_q  <= '0;
      bytecnt_q <= '0;
      ovf_q     <= 1'b0;
      span_q    <= '0;
      limit_q   <= '0;
    end else begin
      span_q  <= SpanW'(period_q) * SpanW'(SILENCE_PERIODS);
      limit_q <= LimW'(prev_q) + LimW'(span_q);
      if (cmd_i.exec) begin
        phase_q   <= phase_d;
        level_q   <= level_d;
        prev_q    <= prev_d;
        next_q    <= next_d;
        total_q   <= total_d;
        count_q   <= count_d;
        asm_q     <= asm_d;
        bitpos_q  <= bitpos_d;
        bytecnt_q <= bytecnt_d;
        ovf_q     <= ovf_d;
        if (op_q == abr_pkg::OP_RESTART) begin
          period_q <= '0;
        end
      end else if (cmd_i.div_load) begin
        period_q <= quot;
        next_q   <= t_q + quot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      t_q   <= sample_time_i;
      pin_q <= pin_level_i;
    end
    if (cmd_i.exec) begin
      res_bv_q   <= res_bv_d;
      res_val_q  <= res_val_d;
      res_idx_q  <= res_idx_d;
      res_bits_q <= res_bits_d;
      res_done_q <= res_done_d;
    end
    if (cmd_i.load_out) begin
      out_phase_q  <= phase_q;
      out_period_q <= period_q;
      out_bv_q     <= res_bv_q;
      out_val_q    <= res_val_q;
      out_idx_q    <= res_idx_q;
      out_bits_q   <= res_bits_q;
      out_done_q   <= res_done_q;
      out_ovf_q    <= ovf_q;
    end
  end

  abr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (total_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign stat_o.need_div = need_div;
  assign stat_o.div_done = div_done;

  assign phase_o        = out_phase_q;
  assign bit_period_o   = out_period_q;
  assign byte_valid_o   = out_bv_q;
  assign byte_value_o   = out_val_q;
  assign byte_index_o   = out_idx_q;
  assign bits_in_byte_o = out_bits_q;
  assign done_res_o     = out_done_q;
  assign overflow_o     = out_ovf_q;

endmodule

`default_nettype wire

### sv/abr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module abr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output abr_pkg::cmd_t        cmd_o,
  input  wire abr_pkg::stat_t  stat_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= stat_i.need_div ? ST_DIV_START : ST_FINISH;
        end
        ST_DIV_START: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (stat_i.div_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cmd_o.capture     = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.exec        = (state_q == ST_EXEC);
  assign cmd_o.div_start   = (state_q == ST_DIV_START);
  assign cmd_o.div_load    = (state_q == ST_DIV_WAIT) && stat_i.div_done;
  assign cmd_o.load_out    = (state_q == ST_FINISH) && out_free;

endmodule

`default_nettype wire

### sv/autobaud_serial_bit_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Auto-baud serial bit receiver. Each request is a timestamped pin sample
// (op 0) or a restart (op 1, which takes the current pin level as reference).
// The block locks onto the bit period by averaging the first SYNC_EDGES edge
// spacings, keeps refining the average while edges keep arriving, and
// switches to receiving once an expected edge is more than half a period late.
// It then samples once per period, packs bits LSB first and reports bytes;
// SILENCE_PERIODS periods without an edge end the message and flush a partial
// byte with its bit count. Bytes beyond BUFFER_BYTES are dropped and the
// sticky overflow flag goes high. Every request yields exactly one result.
// Timing: a request is taken when in_valid_i is high and in_stall_o is low;
// in_stall_o stays high until its result has been moved to the output
// register, so a result waiting on out_stall_i does not block the next
// request. A request that does not update the average passes through the
// capture register and then the result register. A request that sets or
// updates it (the edge that completes sync, or an edge while tracking) also
// runs the shared shift-subtract divider (one quotient bit per cycle, 32
// bits) before its result is ready.

module autobaud_serial_bit_receiver #(
  parameter int BUFFER_BYTES    = abr_pkg::BufferBytesDef,
  parameter int SYNC_EDGES      = abr_pkg::SyncEdgesDef,
  parameter int SILENCE_PERIODS = abr_pkg::SilencePeriodsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Request channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        op_i,
  input  wire logic [abr_pkg::TimeW-1:0]   sample_time_i,
  input  wire logic                        pin_level_i,
  // Result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [2:0]                       phase_o,
  output logic [abr_pkg::TimeW-1:0]        bit_period_o,
  output logic                             byte_valid_o,
  output logic [7:0]                       byte_value_o,
  output logic [abr_pkg::IdxW-1:0]         byte_index_o,
  output logic [abr_pkg::BitsW-1:0]        bits_in_byte_o,
  output logic                             done_res_o,
  output logic                             overflow_o
);

  abr_pkg::cmd_t  cmd;
  abr_pkg::stat_t stat;

  // Sequencer: capture, execute, optional divide, hand off to the output
  abr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // State registers, step logic, divider and result register. The silence
  // limit is registered in two stages behind the period and edge time; the
  // finish and idle cycles between two executes give it time to settle.
  abr_dp #(
    .BUFFER_BYTES    (BUFFER_BYTES),
    .SYNC_EDGES      (SYNC_EDGES),
    .SILENCE_PERIODS (SILENCE_PERIODS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (op_i),
    .sample_time_i  (sample_time_i),
    .pin_level_i    (pin_level_i),
    .phase_o        (phase_o),
    .bit_period_o   (bit_period_o),
    .byte_valid_o   (byte_valid_o),
    .byte_value_o   (byte_value_o),
    .byte_index_o   (byte_index_o),
    .bits_in_byte_o (bits_in_byte_o),
    .done_res_o     (done_res_o),
    .overflow_o     (overflow_o)
  );

endmodule

`default_nettype wire

### sv/abr_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module abr_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [2:0]                  phase_o,
  input wire logic [abr_pkg::TimeW-1:0]   bit_period_o,
  input wire logic                        byte_valid_o,
  input wire logic [7:0]                  byte_value_o,
  input wire logic [abr_pkg::IdxW-1:0]    byte_index_o,
  input wire logic [abr_pkg::BitsW-1:0]   bits_in_byte_o,
  input wire logic                        done_res_o,
  input wire logic                        overflow_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_value_o))
    else $error("stalled result dropped or changed");

  a_byte_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> bits_in_byte_o != '0 && bits_in_byte_o <= 4'd8)
    else $error("byte reported with bad bit count");

  a_no_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |->
      byte_value_o == '0 && byte_index_o == '0 && bits_in_byte_o == '0)
    else $error("byte fields not zero without a byte");

  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> phase_o == abr_pkg::PH_DONE)
    else $error("completion reported outside complete phase");

  a_wait_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == abr_pkg::PH_WAIT |-> !overflow_o && bit_period_o == '0)
    else $error("waiting phase with leftover period or overflow");

endmodule

bind autobaud_serial_bit_receiver abr_chk u_abr_chk (.*);

`default_nettype wire

### verif/autobaud_checker.sv
`timescale 1ns / 1ps

module autobaud_checker #(
  parameter int BUFFER_BYTES    = abr_pkg::BufferBytesDef,
  parameter int SYNC_EDGES      = abr_pkg::SyncEdgesDef,
  parameter int SILENCE_PERIODS = abr_pkg::SilencePeriodsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        op_i,
  input  logic [abr_pkg::TimeW-1:0]   sample_time_i,
  input  logic                        pin_level_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [2:0]                  phase_i,
  input  logic [abr_pkg::TimeW-1:0]   bit_period_i,
  input  logic                        byte_valid_i,
  input  logic [7:0]                  byte_value_i,
  input  logic [abr_pkg::IdxW-1:0]    byte_index_i,
  input  logic [abr_pkg::BitsW-1:0]   bits_in_byte_i,
  input  logic                        done_res_i,
  input  logic                        overflow_i,
  output int                          mismatch_count_o,
  output int                          pending_o
);

  typedef struct packed {
    abr_pkg::phase_e                phase;
    logic [abr_pkg::TimeW-1:0]      bit_period;
    logic                           byte_valid;
    logic [7:0]                     byte_value;
    logic [abr_pkg::IdxW-1:0]       byte_index;
    logic [abr_pkg::BitsW-1:0]      bits_in_byte;
    logic                           done;
    logic                           overflow;
  } rx_report_t;

  // Receiver state as the block should hold it
  abr_pkg::phase_e              ph;
  logic                         lvl;
  logic [abr_pkg::TimeW-1:0]    edge_t;
  logic [abr_pkg::TimeW-1:0]    next_t;
  logic [abr_pkg::TimeW-1:0]    span_sum;
  logic [abr_pkg::CountW-1:0]   edge_cnt;
  logic [abr_pkg::TimeW-1:0]    period;
  logic [7:0]                   shift_byte;
  logic [3:0]                   bit_pos;
  int unsigned                  bytes_seen;
  logic                         ovf;

  rx_report_t predicted_reports[$];
  int mismatches;
  int pending;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  function automatic void clear_receiver();
    ph         = abr_pkg::PH_WAIT;
    lvl        = 1'b0;
    edge_t     = '0;
    next_t     = '0;
    span_sum   = '0;
    edge_cnt   = '0;
    period     = '0;
    shift_byte = '0;
    bit_pos    = '0;
    bytes_seen = 0;
    ovf        = 1'b0;
  endfunction

  function automatic void count_edge(input logic [abr_pkg::TimeW-1:0] t);
    span_sum += t - edge_t;
    if (edge_cnt != abr_pkg::CountMax) edge_cnt++;
    edge_t = t;
  endfunction

  function automatic void refresh_period(input logic [abr_pkg::TimeW-1:0] t);
    period = (edge_cnt != '0) ? span_sum / {16'b0, edge_cnt} : '0;
    next_t = t + period;
  endfunction

  // Drop the byte and raise the sticky flag once the buffer is full
  function automatic void emit_byte(inout rx_report_t r, input logic [7:0] value,
                                    input logic [3:0] nbits);
    if (bytes_seen < BUFFER_BYTES) begin
      r.byte_valid   = 1'b1;
      r.byte_value   = value;
      r.byte_index   = bytes_seen[abr_pkg::IdxW-1:0];
      r.bits_in_byte = nbits;
      bytes_seen++;
    end else begin
      ovf = 1'b1;
    end
  endfunction

  function automatic rx_report_t track_pin_sample(input logic op,
                                                  input logic [abr_pkg::TimeW-1:0] t,
                                                  input logic pin);
    rx_report_t r;
    logic [abr_pkg::TimeW-1:0] half;
    logic [63:0] limit;
    r = '0;
    if (op == abr_pkg::OP_RESTART) begin
      clear_receiver();
      lvl = pin;
    end else begin
      case (ph)
        abr_pkg::PH_WAIT: begin
          if (pin != lvl) begin
            edge_t   = t;
            lvl      = pin;
            edge_cnt = '0;
            ph       = abr_pkg::PH_SYNC;
          end
        end
        abr_pkg::PH_SYNC: begin
          if (pin != lvl) begin
            lvl = pin;
            count_edge(t);
            if (edge_cnt >= SYNC_EDGES) begin
              ph = abr_pkg::PH_TRACK;
              refresh_period(t);
            end
          end
        end
        abr_pkg::PH_TRACK: begin
          half = period >> 1;
          // the deadline sum must not wrap
          if ({32'b0, t} > {32'b0, next_t} + {32'b0, half}) begin
            ph         = abr_pkg::PH_RECV;
            next_t     = t + half;
            edge_t     = t;
            shift_byte = {7'b0, pin};
            bit_pos    = 4'd1;
            bytes_seen = 0;
            lvl        = pin;
          end else if (pin != lvl) begin
            lvl = pin;
            count_edge(t);
            refresh_period(t);
          end
        end
        abr_pkg::PH_RECV: begin
          if (t >= next_t) begin
            next_t += period;
            shift_byte |= 8'(pin) << bit_pos[2:0];
            bit_pos++;
            if (bit_pos >= 4'd8) begin
              emit_byte(r, shift_byte, 4'd8);
              shift_byte = '0;
              bit_pos    = '0;
            end
            if (lvl == pin) begin
              limit = {32'b0, edge_t} + 64'(period) * 64'(SILENCE_PERIODS);
              if (limit < {32'b0, t}) begin
                ph     = abr_pkg::PH_DONE;
                r.done = 1'b1;
                if (bit_pos != '0) begin
                  emit_byte(r, shift_byte, bit_pos);
                  shift_byte = '0;
                  bit_pos    = '0;
                end
              end
            end else begin
              lvl    = pin;
              edge_t = t;
            end
          end
        end
        default: ;
      endcase
    end
    r.phase      = ph;
    r.bit_period = period;
    r.overflow   = ovf;
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0d, got %0d", $realtime, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rx_report_t want;
    if (!rst_ni) begin
      clear_receiver();
      predicted_reports.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request pending, phase %0d", $realtime, phase_i);
        end else begin
          want = predicted_reports.pop_front();
          compare_field("phase", want.phase, phase_i);
          compare_field("bit_period", want.bit_period, bit_period_i);
          compare_field("byte_valid", want.byte_valid, byte_valid_i);
          compare_field("byte_value", want.byte_value, byte_value_i);
          compare_field("byte_index", want.byte_index, byte_index_i);
          compare_field("bits_in_byte", want.bits_in_byte, bits_in_byte_i);
          compare_field("done_res", want.done, done_res_i);
          compare_field("overflow", want.overflow, overflow_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        predicted_reports.push_back(track_pin_sample(op_i, sample_time_i, pin_level_i));
      pending = predicted_reports.size();
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RandomRequests = 1100;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic                         op_i          = abr_pkg::OP_SAMPLE;
  logic [abr_pkg::TimeW-1:0]    sample_time_i = '0;
  logic                         pin_level_i   = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic [2:0]                   phase_o;
  logic [abr_pkg::TimeW-1:0]    bit_period_o;
  logic                         byte_valid_o;
  logic [7:0]                   byte_value_o;
  logic [abr_pkg::IdxW-1:0]     byte_index_o;
  logic [abr_pkg::BitsW-1:0]    bits_in_byte_o;
  logic                         done_res_o;
  logic                         overflow_o;

  int fail_count;
  int pending_results;

  // Pacing knobs for the request driver and the result sink
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  int hold_cycles  = 0;
  int requests_sent;

  always #2 clk_i = ~clk_i;

  autobaud_serial_bit_receiver DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .sample_time_i  (sample_time_i),
    .pin_level_i    (pin_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .phase_o        (phase_o),
    .bit_period_o   (bit_period_o),
    .byte_valid_o   (byte_valid_o),
    .byte_value_o   (byte_value_o),
    .byte_index_o   (byte_index_o),
    .bits_in_byte_o (bits_in_byte_o),
    .done_res_o     (done_res_o),
    .overflow_o     (overflow_o)
  );

  autobaud_checker report_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .op_i             (op_i),
    .sample_time_i    (sample_time_i),
    .pin_level_i      (pin_level_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .phase_i          (phase_o),
    .bit_period_i     (bit_period_o),
    .byte_valid_i     (byte_valid_o),
    .byte_value_i     (byte_value_o),
    .byte_index_i     (byte_index_o),
    .bits_in_byte_i   (bits_in_byte_o),
    .done_res_i       (done_res_o),
    .overflow_i       (overflow_o),
    .mismatch_count_o (fail_count),
    .pending_o        (pending_results)
  );

  // Result sink: stall at random, or hold off for a counted stretch when
  // the stimulus asks for it so the block backs up into its request side.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= sink_idle_en && ($urandom_range(99, 0) < 34);
      end
    end
  end

  // Offer one request and hold it until the block takes it. Every call
  // starts and ends just after a rising edge; a caller that stops sending
  // must drop valid in that same step.
  task automatic offer(input logic op, input logic [abr_pkg::TimeW-1:0] t,
                       input logic pin);
    while (src_idle_en && $urandom_range(99, 0) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    sample_time_i <= t;
    pin_level_i   <= pin;
    do @(posedge clk_i); while (in_stall_o);
    requests_sent++;
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // Mostly short bit periods; now and then a huge one to stress the divider
  // and the wide deadline sums.
  function automatic logic [abr_pkg::TimeW-1:0] pick_period();
    if ($urandom_range(7, 0) == 0) return $urandom_range(32'h0100_0000, 32'h1000);
    return $urandom_range(400, 4);
  endfunction

  // One message on the line: restart at the idle level, a preamble of
  // alternating edges, a two-period hold so the tracker misses an edge and
  // starts receiving, the data bits LSB first, then silence. Samples fall
  // mid-cell (coarse) or every half period (fine). The silence is either a
  // single late sample somewhere around the limit or a slow walk past it.
  task automatic send_message(input logic [abr_pkg::TimeW-1:0] p, input int edges,
                              input int nbytes, input bit fine, input bit jitter,
                              input bit abrupt);
    bit data_bits[$];
    logic lvl;
    logic tail_lvl;
    logic [abr_pkg::TimeW-1:0] t;
    logic [abr_pkg::TimeW-1:0] last_edge;
    logic [abr_pkg::TimeW-1:0] tick_t;
    logic [abr_pkg::TimeW-1:0] stop_t;
    logic [abr_pkg::TimeW-1:0] step;
    int cell_idx;
    repeat (nbytes * 8) data_bits.push_back($urandom_range(1, 0));
    lvl = $urandom_range(1, 0);
    // keep the whole message clear of the 32-bit wrap
    t = (p > 65536) ? $urandom_range(32'h3FFF_FFFF, 0) : $urandom_range(32'hF000_0000, 0);
    offer(abr_pkg::OP_RESTART, t, lvl);
    repeat ($urandom_range(2, 0)) begin
      t += $urandom_range(p, 1);
      offer(abr_pkg::OP_SAMPLE, t, lvl);
    end
    repeat (edges) begin
      t += jitter ? p - p / 16 + $urandom_range(p / 8, 0) : p;
      lvl = ~lvl;
      offer(abr_pkg::OP_SAMPLE, t, lvl);
      if (fine && $urandom_range(1, 0)) offer(abr_pkg::OP_SAMPLE, t + p / 2, lvl);
    end
    last_edge = t;
    step      = fine ? p / 2 : p;
    stop_t    = last_edge + (2 + data_bits.size()) * p;
    tick_t    = last_edge + p / 2;
    while (tick_t < stop_t) begin
      cell_idx = int'((tick_t - last_edge) / p);
      offer(abr_pkg::OP_SAMPLE, tick_t, (cell_idx < 2) ? lvl : data_bits[cell_idx - 2]);
      tick_t += step;
    end
    tail_lvl = (data_bits.size() == 0) ? lvl : data_bits[data_bits.size() - 1];
    if (abrupt) begin
      offer(abr_pkg::OP_SAMPLE, tick_t + p * $urandom_range(80, 30), tail_lvl);
    end else begin
      repeat (12) begin
        tick_t += 4 * p;
        offer(abr_pkg::OP_SAMPLE, tick_t, tail_lvl);
      end
    end
  endtask

  initial begin : stimulus
    int msg_idx;
    int pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Edge spacings that wrap the sum: the average comes out as 8 and the
    // timeout then fires from a time near the top of the range.
    offer(abr_pkg::OP_RESTART, 32'h0, 1'b1);
    offer(abr_pkg::OP_SAMPLE, 32'h0, 1'b1);
    offer(abr_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    offer(abr_pkg::OP_SAMPLE, 32'h0, 1'b1);
    offer(abr_pkg::OP_SAMPLE, 32'h8000_0000, 1'b0);
    offer(abr_pkg::OP_SAMPLE, 32'hFFFF_FFF0, 1'b1);
    offer(abr_pkg::OP_SAMPLE, 32'h20, 1'b0);
    offer(abr_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    offer(abr_pkg::OP_SAMPLE, 32'h10, 1'b1);
    offer(abr_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b1);
    // Huge period: the tracking deadline lands past 2^32 and must not fire
    offer(abr_pkg::OP_RESTART, 32'h55, 1'b0);
    offer(abr_pkg::OP_SAMPLE, 32'h0, 1'b1);
    offer(abr_pkg::OP_SAMPLE, 32'h3000_0000, 1'b0);
    offer(abr_pkg::OP_SAMPLE, 32'h6000_0000, 1'b1);
    offer(abr_pkg::OP_SAMPLE, 32'h9000_0000, 1'b0);
    offer(abr_pkg::OP_SAMPLE, 32'hC000_0000, 1'b1);
    offer(abr_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b1);
    offer(abr_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b0);

    // Random part: mostly well-formed messages, some with a short preamble,
    // and bursts of raw noise over the whole field range.
    requests_sent = 0;
    msg_idx       = 0;
    while (requests_sent < RandomRequests) begin
      if (msg_idx == 4) hold_cycles = 400;
      if (msg_idx == 9) drain_results();
      if (msg_idx == 14) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      if (msg_idx == 22) begin
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
      end
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        send_message(pick_period(), 1 + abr_pkg::SyncEdgesDef + $urandom_range(5, 0),
                     $urandom_range(4, 0), $urandom_range(1, 0), 1'b1, $urandom_range(1, 0));
      end else if (pick < 85) begin
        send_message(pick_period(), $urandom_range(abr_pkg::SyncEdgesDef, 0),
                     $urandom_range(2, 0), $urandom_range(1, 0), 1'b1,
                     $urandom_range(1, 0));
      end else begin
        repeat ($urandom_range(8, 1))
          offer(($urandom_range(7, 0) == 0) ? abr_pkg::OP_RESTART : abr_pkg::OP_SAMPLE,
                $urandom, $urandom_range(1, 0));
      end
      msg_idx++;
    end

    // One longer message at a short fixed period, one sample per bit, to run
    // a dozen full bytes through in a row.
    send_message(32'd16, 3 + abr_pkg::SyncEdgesDef, 12, 1'b0, 1'b0, 1'b1);
    offer(abr_pkg::OP_RESTART, $urandom, $urandom_range(1, 0));

    drain_results();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
